### hw/rtl/sfra_pkg.sv
// ---------------------------------------------------------------------------
// sfra_pkg
// shared types, field widths and helpers of the segregated-fit range allocator
// ---------------------------------------------------------------------------
package sfra_pkg;

  localparam int ADDR_FIELD_W = 48;
  localparam int LEN_FIELD_W  = 49;
  localparam int STAMP_W      = 32;
  // widest page count over the supported page sizes
  localparam int CNT_MAX_W    = 41;
  localparam int CLS_W        = 6;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int PAGE_BITS_DEF     = 12;
  localparam int ADDRESS_BITS_DEF  = 48;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_ALLOC  = 2'd1,
    CMD_FREE   = 2'd2,
    CMD_RESIZE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FIT  = 2'd1,
    ST_FULL    = 2'd2,
    ST_BAD     = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t                    cmd;
    logic [ADDR_FIELD_W-1:0] address;
    logic [ADDR_FIELD_W-1:0] end_address;
    logic [LEN_FIELD_W-1:0]  length;
    logic [LEN_FIELD_W-1:0]  new_length;
  } req_t;

  typedef struct packed {
    status_t                 status;
    logic [ADDR_FIELD_W-1:0] result_address;
  } rsp_t;

  // per-entry match results of the compare unit
  typedef struct packed {
    logic empty;
    logic at_alloc;
    logic ends_at;
    logic starts_at;
    logic overlaps;
    logic free_live;
    logic newer;
  } hit_t;

  // floor log2, zero for zero
  function automatic logic [CLS_W-1:0] class_of(input logic [CNT_MAX_W-1:0] n);
    logic [CLS_W-1:0] c;
    c = '0;
    for (int i = 1; i < CNT_MAX_W; i++) begin
      if (n[i]) c = CLS_W'(i);
    end
    return c;
  endfunction

endpackage

### hw/rtl/sfra_ram.sv
// ---------------------------------------------------------------------------
// sfra_ram
// generic simple dual-port ram, one write port, registered read
// ---------------------------------------------------------------------------
module sfra_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/sfra_match.sv
// ---------------------------------------------------------------------------
// sfra_match
// shared compare unit: checks one table entry against the request keys
// ---------------------------------------------------------------------------
module sfra_match #(
  parameter int SPW = 36,
  parameter int CW  = 37,
  parameter int EW  = 38
) (
  input  logic                          live,
  input  logic                          is_free,
  input  logic [SPW-1:0]                ent_start,
  input  logic [CW-1:0]                 ent_cnt,
  input  logic [sfra_pkg::STAMP_W-1:0]  ent_stamp,
  input  logic [SPW-1:0]                key_start,
  input  logic [EW-1:0]                 key_end,
  input  logic [EW-1:0]                 key_next,
  input  logic [sfra_pkg::CLS_W-1:0]    ord,
  input  logic [CW-1:0]                 min_pages,
  input  logic [sfra_pkg::STAMP_W-1:0]  age,
  input  logic                          best_found,
  input  logic [sfra_pkg::STAMP_W-1:0]  best_dist,
  output sfra_pkg::hit_t                hit,
  output logic [sfra_pkg::CLS_W-1:0]    ent_class,
  output logic [sfra_pkg::STAMP_W-1:0]  age_gap
);
  import sfra_pkg::*;

  logic [EW-1:0] ent_end;

  assign ent_end   = EW'(ent_start) + EW'(ent_cnt);
  assign ent_class = class_of(CNT_MAX_W'(ent_cnt));
  assign age_gap   = age - ent_stamp;

  always_comb begin
    hit.empty     = !live;
    hit.at_alloc  = live && !is_free && (ent_start == key_start);
    hit.ends_at   = live && is_free && (ent_end == key_end);
    hit.starts_at = live && is_free && (EW'(ent_start) == key_next);
    hit.overlaps  = live && (EW'(ent_start) < key_next) && (key_end < ent_end);
    hit.free_live = live && is_free;
    hit.newer     = live && is_free && (ent_class == ord) && (ent_cnt >= min_pages) &&
                    (!best_found || (age_gap < best_dist));
  end

endmodule

### hw/rtl/segregated_fit_range_allocator.sv
// ---------------------------------------------------------------------------
// segregated_fit_range_allocator
// page range allocator with power-of-two size classes over a slot table
// ---------------------------------------------------------------------------
// One request at a time. Each request is checked, then the table is swept
// through the shared compare unit (one slot per cycle from the start, count
// and stamp rams), then a short update sequence writes the result. Add, free
// and resize sweep once; allocate sweeps twice, once to find which size
// classes hold free ranges and once for the newest range of the chosen
// class. Requests rejected by the first checks answer without a sweep. A
// finished response waits in the output register while the next request is
// taken; a second finished response holds the input until the first one is
// handed over. Start, count and stamp rams need no clearing after reset: the
// in-use bits guard them.
// ---------------------------------------------------------------------------
module segregated_fit_range_allocator #(
  parameter int TABLE_ENTRIES = sfra_pkg::TABLE_ENTRIES_DEF,
  parameter int PAGE_BITS     = sfra_pkg::PAGE_BITS_DEF,
  parameter int ADDRESS_BITS  = sfra_pkg::ADDRESS_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  sfra_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output sfra_pkg::rsp_t rsp
);
  import sfra_pkg::*;

  // effective address width, start page, page count and sum widths
  localparam int AW  = (ADDRESS_BITS < ADDR_FIELD_W) ? ADDRESS_BITS : ADDR_FIELD_W;
  localparam int SPW = AW - PAGE_BITS;
  localparam int CW  = LEN_FIELD_W - PAGE_BITS;
  localparam int EW  = CW + 1;
  localparam int IW  = $clog2(TABLE_ENTRIES);
  localparam int NW  = IW + 1;
  localparam int CLW = CLS_W;

  localparam logic [ADDR_FIELD_W-1:0] AMASK = ADDR_FIELD_W'((65'd1 << AW) - 65'd1);
  localparam logic [ADDR_FIELD_W-1:0] PMASK = ADDR_FIELD_W'((65'd1 << PAGE_BITS) - 65'd1);
  localparam logic [LEN_FIELD_W-1:0]  LMASK = LEN_FIELD_W'((65'd1 << PAGE_BITS) - 65'd1);
  localparam logic [NW-1:0]           LAST  = NW'(TABLE_ENTRIES);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_PREP  = 13'b0000000000010,
    S_CHECK = 13'b0000000000100,
    S_SCAN  = 13'b0000000001000,
    S_ASEL  = 13'b0000000010000,
    S_MRG   = 13'b0000000100000,
    S_SUM1  = 13'b0000001000000,
    S_SUM2  = 13'b0000010000000,
    S_NEWF  = 13'b0000100000000,
    S_SETF  = 13'b0001000000000,
    S_RWI   = 13'b0010000000000,
    S_GWR   = 13'b0100000000000,
    S_AWR   = 13'b1000000000000
  } state_t;

  state_t state;
  logic   done_pend;

  // latched request and derived values
  req_t            q;
  logic            bad0;
  logic            misal;
  logic [SPW-1:0]  hp;
  logic [SPW-1:0]  lp;
  logic [SPW-1:0]  ka;
  logic [CW-1:0]   lenp;
  logic [CW-1:0]   np;
  logic [CLW-1:0]  mo;
  logic            pow2;
  logic            shrink;

  // sweep keys and merge span
  logic [EW-1:0]   kend;
  logic [EW-1:0]   knx;
  logic [SPW-1:0]  mstart;
  logic [CW-1:0]   mcnt;

  // table flags
  logic [TABLE_ENTRIES-1:0] inuse;
  logic [TABLE_ENTRIES-1:0] isfree;
  logic [STAMP_W-1:0]       age;

  // sweep control
  logic [NW-1:0]   ic;
  logic            pv;
  logic [IW-1:0]   pidx;
  logic            pass1;

  // sweep trackers
  logic            e_f;
  logic [IW-1:0]   e_idx;
  logic            a_f;
  logic [IW-1:0]   a_idx;
  logic [CW-1:0]   a_cnt;
  logic            p_f;
  logic [IW-1:0]   p_idx;
  logic [CW-1:0]   p_cnt;
  logic            n_f;
  logic [IW-1:0]   n_idx;
  logic [CW-1:0]   n_cnt;
  logic            ovl;
  logic [CW-1:0]   bm;
  logic            b_f;
  logic [IW-1:0]   b_idx;
  logic [SPW-1:0]  b_start;
  logic [CW-1:0]   b_cnt;
  logic [STAMP_W-1:0] b_dist;

  // class search
  logic [CLW-1:0]  ord;
  logic [CW-1:0]   minp;

  // update plan for a free entry whose size changes
  logic [IW-1:0]   wi;
  logic [SPW-1:0]  wstart;
  logic            wstart_en;
  logic [CW-1:0]   old_cnt;
  logic [CW-1:0]   nsum;

  status_t                 st;
  logic [ADDR_FIELD_W-1:0] res;

  // ram ports
  logic               s_we, c_we, t_we;
  logic [IW-1:0]      s_wa, c_wa, t_wa;
  logic [SPW-1:0]     s_wd;
  logic [CW-1:0]      c_wd;
  logic [STAMP_W-1:0] t_wd;
  logic [SPW-1:0]     s_rd;
  logic [CW-1:0]      c_rd;
  logic [STAMP_W-1:0] t_rd;

  hit_t               hit;
  logic [CLW-1:0]     ent_class;
  logic [STAMP_W-1:0] age_gap;
  logic               cls_chg;
  logic               scan_done;

  // prep arithmetic
  logic [ADDR_FIELD_W-1:0] addr_m;
  logic [ADDR_FIELD_W-1:0] tail_m;
  logic [ADDR_FIELD_W-1:0] hsum;
  logic [ADDR_FIELD_W-1:0] tsub;
  logic [CW-1:0]           len_pages;

  // class choice for allocate
  logic [CLW-1:0] thr;
  logic           hi_found;
  logic [CLW-1:0] hi_ord;

  // a response still waiting for the output register holds the input
  assign req_ready = (state == S_IDLE) && !done_pend;
  assign scan_done = (ic == LAST) && !pv;
  assign cls_chg   = class_of(CNT_MAX_W'(old_cnt)) != class_of(CNT_MAX_W'(nsum));

  assign addr_m    = q.address & AMASK;
  assign tail_m    = q.end_address & AMASK;
  assign hsum      = addr_m + PMASK;
  assign tsub      = tail_m - PMASK;
  assign len_pages = q.length[PAGE_BITS +: CW];

  always_comb begin
    thr      = mo + (pow2 ? CLW'(0) : CLW'(1));
    hi_found = 1'b0;
    hi_ord   = '0;
    for (int i = CW - 1; i >= 0; i--) begin
      if (bm[i] && (CLW'(i) >= thr)) begin
        hi_found = 1'b1;
        hi_ord   = CLW'(i);
      end
    end
  end

  // slot rams, all read by the sweep index
  sfra_ram #(.WIDTH(SPW), .DEPTH(TABLE_ENTRIES)) u_start_ram (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(ic[IW-1:0]), .rdata(s_rd)
  );

  sfra_ram #(.WIDTH(CW), .DEPTH(TABLE_ENTRIES)) u_count_ram (
    .clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(ic[IW-1:0]), .rdata(c_rd)
  );

  sfra_ram #(.WIDTH(STAMP_W), .DEPTH(TABLE_ENTRIES)) u_stamp_ram (
    .clk(clk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(ic[IW-1:0]), .rdata(t_rd)
  );

  sfra_match #(.SPW(SPW), .CW(CW), .EW(EW)) u_match (
    .live(inuse[pidx]),
    .is_free(isfree[pidx]),
    .ent_start(s_rd),
    .ent_cnt(c_rd),
    .ent_stamp(t_rd),
    .key_start(ka),
    .key_end(kend),
    .key_next(knx),
    .ord(ord),
    .min_pages(minp),
    .age(age),
    .best_found(b_f),
    .best_dist(b_dist),
    .hit(hit),
    .ent_class(ent_class),
    .age_gap(age_gap)
  );

  // ram writes of the update sequence
  always_comb begin
    s_we = 1'b0; s_wa = '0; s_wd = '0;
    c_we = 1'b0; c_wa = '0; c_wd = '0;
    t_we = 1'b0; t_wa = '0; t_wd = '0;
    case (state)
      S_NEWF: begin
        s_we = 1'b1; s_wa = e_idx; s_wd = mstart;
        c_we = 1'b1; c_wa = e_idx; c_wd = mcnt;
        t_we = 1'b1; t_wa = e_idx; t_wd = age;
      end
      S_SETF: begin
        s_we = wstart_en; s_wa = wi; s_wd = wstart;
        c_we = 1'b1;      c_wa = wi; c_wd = nsum;
        t_we = cls_chg;   t_wa = wi; t_wd = age;
      end
      S_RWI, S_GWR: begin
        c_we = 1'b1; c_wa = a_idx; c_wd = np;
      end
      S_AWR: begin
        s_we = 1'b1; s_wa = e_idx; s_wd = b_start;
        c_we = 1'b1; c_wa = e_idx; c_wd = lenp;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done_pend <= 1'b0;
      rsp_valid <= 1'b0;
      inuse     <= '0;
      isfree    <= '0;
      age       <= '0;
      pv        <= 1'b0;
      ic        <= '0;
    end else begin
      // finished response goes out once the output register is free
      if (done_pend && (!rsp_valid || rsp_ready)) begin
        rsp_valid          <= 1'b1;
        rsp.status         <= st;
        rsp.result_address <= (st == ST_OK) ? res : '0;
        done_pend          <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req_valid && req_ready) begin
            q     <= req;
            state <= S_PREP;
          end
        end

        S_PREP: begin
          hp    <= hsum[PAGE_BITS +: SPW];
          lp    <= tsub[PAGE_BITS +: SPW];
          ka    <= addr_m[PAGE_BITS +: SPW];
          lenp  <= len_pages;
          np    <= q.new_length[PAGE_BITS +: CW];
          mo    <= class_of(CNT_MAX_W'(len_pages));
          pow2  <= (len_pages & (len_pages - CW'(1))) == '0;
          misal <= ((addr_m & PMASK) != '0) || ((q.length & LMASK) != '0);
          case (q.cmd)
            CMD_ADD:   bad0 <= (addr_m > (AMASK - PMASK)) || (tail_m < PMASK);
            CMD_ALLOC: bad0 <= (q.length == '0) || ((q.length & LMASK) != '0);
            CMD_FREE:  bad0 <= ((addr_m & PMASK) != '0) || ((q.length & LMASK) != '0);
            default:   bad0 <= (q.new_length == '0) || ((q.new_length & LMASK) != '0);
          endcase
          state <= S_CHECK;
        end

        S_CHECK: begin
          // clear the sweep trackers
          e_f <= 1'b0; a_f <= 1'b0; p_f <= 1'b0; n_f <= 1'b0; b_f <= 1'b0;
          ovl <= 1'b0; bm <= '0; ic <= '0; pv <= 1'b0; pass1 <= 1'b0;
          res <= '0;
          shrink <= 1'b0;
          case (q.cmd)
            CMD_ADD: begin
              if (bad0 || (hp > lp)) begin
                st <= ST_BAD; done_pend <= 1'b1; state <= S_IDLE;
              end else begin
                state <= S_SCAN;
              end
              kend   <= EW'(hp);
              knx    <= EW'(lp) + EW'(1);
              mstart <= hp;
              mcnt   <= CW'(lp) - CW'(hp) + CW'(1);
            end
            CMD_ALLOC: begin
              if (bad0) begin
                st <= ST_BAD; done_pend <= 1'b1; state <= S_IDLE;
              end else begin
                state <= S_SCAN;
              end
            end
            CMD_FREE: begin
              if (bad0) begin
                st <= ST_BAD; done_pend <= 1'b1; state <= S_IDLE;
              end else begin
                state <= S_SCAN;
              end
              kend   <= EW'(ka);
              knx    <= EW'(ka) + EW'(lenp);
              mstart <= ka;
              mcnt   <= lenp;
            end
            default: begin
              // new size checked first, an unchanged size needs no lookup
              if (bad0) begin
                st <= ST_BAD; done_pend <= 1'b1; state <= S_IDLE;
              end else if (q.length == q.new_length) begin
                st <= ST_OK; done_pend <= 1'b1; state <= S_IDLE;
              end else if (misal) begin
                st <= ST_BAD; done_pend <= 1'b1; state <= S_IDLE;
              end else begin
                state <= S_SCAN;
              end
              kend   <= EW'(ka) + EW'(np);
              knx    <= EW'(ka) + EW'(lenp);
              mstart <= SPW'(EW'(ka) + EW'(np));
              shrink <= np < lenp;
              mcnt   <= (np < lenp) ? (lenp - np) : (np - lenp);
            end
          endcase
        end

        S_SCAN: begin
          if (ic != LAST) begin
            ic   <= ic + NW'(1);
            pv   <= 1'b1;
            pidx <= ic[IW-1:0];
          end else begin
            pv <= 1'b0;
          end
          if (pv) begin
            if (hit.empty && !e_f) begin
              e_f <= 1'b1; e_idx <= pidx;
            end
            if (hit.at_alloc && !a_f) begin
              a_f <= 1'b1; a_idx <= pidx; a_cnt <= c_rd;
            end
            if (hit.ends_at && !p_f) begin
              p_f <= 1'b1; p_idx <= pidx; p_cnt <= c_rd;
            end
            if (hit.starts_at && !n_f) begin
              n_f <= 1'b1; n_idx <= pidx; n_cnt <= c_rd;
            end
            if (hit.overlaps) ovl <= 1'b1;
            if (hit.free_live && !pass1) bm <= bm | (CW'(1) << ent_class);
            if (hit.newer && pass1) begin
              b_f <= 1'b1; b_idx <= pidx; b_start <= s_rd; b_cnt <= c_rd; b_dist <= age_gap;
            end
          end
          if (scan_done) begin
            case (q.cmd)
              CMD_ADD: begin
                if (ovl) begin
                  st <= ST_BAD; done_pend <= 1'b1; state <= S_IDLE;
                end else begin
                  state <= S_MRG;
                end
              end
              CMD_ALLOC: begin
                if (!pass1) begin
                  state <= S_ASEL;
                end else if (!b_f) begin
                  st <= ST_NO_FIT; done_pend <= 1'b1; state <= S_IDLE;
                end else begin
                  res <= ADDR_FIELD_W'(b_start) << PAGE_BITS;
                  if (b_cnt > lenp) begin
                    if (!e_f) begin
                      st <= ST_FULL; done_pend <= 1'b1; state <= S_IDLE;
                    end else begin
                      state <= S_AWR;
                    end
                  end else begin
                    isfree[b_idx] <= 1'b0;
                    st <= ST_OK; done_pend <= 1'b1; state <= S_IDLE;
                  end
                end
              end
              CMD_FREE: begin
                if (!a_f || (a_cnt != lenp)) begin
                  st <= ST_BAD; done_pend <= 1'b1; state <= S_IDLE;
                end else begin
                  // the freed slot itself may be the lowest empty one
                  inuse[a_idx] <= 1'b0;
                  e_f          <= 1'b1;
                  e_idx        <= (!e_f || (a_idx < e_idx)) ? a_idx : e_idx;
                  state        <= S_MRG;
                end
              end
              default: begin
                if (!a_f || (a_cnt != lenp)) begin
                  st <= ST_BAD; done_pend <= 1'b1; state <= S_IDLE;
                end else if (shrink) begin
                  state <= S_MRG;
                end else if (!n_f || (n_cnt < mcnt)) begin
                  st <= ST_NO_FIT; done_pend <= 1'b1; state <= S_IDLE;
                end else begin
                  state <= S_GWR;
                end
              end
            endcase
          end
        end

        S_ASEL: begin
          // lowest class sure to fit, else the exact class with a size check
          e_f <= 1'b0; b_f <= 1'b0; ic <= '0; pv <= 1'b0; pass1 <= 1'b1;
          if (hi_found) begin
            ord <= hi_ord; minp <= '0; state <= S_SCAN;
          end else if (bm[mo]) begin
            ord <= mo; minp <= lenp; state <= S_SCAN;
          end else begin
            st <= ST_NO_FIT; done_pend <= 1'b1; state <= S_IDLE;
          end
        end

        S_MRG: begin
          if (p_f || n_f) begin
            state <= S_SUM1;
          end else if (e_f) begin
            state <= S_NEWF;
          end else begin
            st <= ST_FULL; done_pend <= 1'b1; state <= S_IDLE;
          end
        end

        S_SUM1: begin
          if (p_f) begin
            // extend the free range below, absorbing the one above
            nsum      <= p_cnt + mcnt;
            wi        <= p_idx;
            old_cnt   <= p_cnt;
            wstart_en <= 1'b0;
            if (n_f) inuse[n_idx] <= 1'b0;
            state <= n_f ? S_SUM2 : S_SETF;
          end else begin
            nsum      <= n_cnt + mcnt;
            wi        <= n_idx;
            old_cnt   <= n_cnt;
            wstart    <= mstart;
            wstart_en <= 1'b1;
            state     <= S_SETF;
          end
        end

        S_SUM2: begin
          nsum  <= nsum + n_cnt;
          state <= S_SETF;
        end

        S_NEWF: begin
          inuse[e_idx]  <= 1'b1;
          isfree[e_idx] <= 1'b1;
          age           <= age + STAMP_W'(1);
          if ((q.cmd == CMD_RESIZE) && shrink) begin
            state <= S_RWI;
          end else begin
            st <= ST_OK; done_pend <= 1'b1; state <= S_IDLE;
          end
        end

        S_SETF: begin
          // a class change makes the range newest in its class
          if (cls_chg) age <= age + STAMP_W'(1);
          if ((q.cmd == CMD_RESIZE) && shrink) begin
            state <= S_RWI;
          end else begin
            st <= ST_OK; done_pend <= 1'b1; state <= S_IDLE;
          end
        end

        S_RWI: begin
          st <= ST_OK; done_pend <= 1'b1; state <= S_IDLE;
        end

        S_GWR: begin
          if (n_cnt == mcnt) begin
            inuse[n_idx] <= 1'b0;
            st <= ST_OK; done_pend <= 1'b1; state <= S_IDLE;
          end else begin
            nsum      <= n_cnt - mcnt;
            wi        <= n_idx;
            old_cnt   <= n_cnt;
            wstart    <= mstart;
            wstart_en <= 1'b1;
            state     <= S_SETF;
          end
        end

        S_AWR: begin
          // split: the new slot takes the head, the rest stays free
          inuse[e_idx]  <= 1'b1;
          isfree[e_idx] <= 1'b0;
          nsum          <= b_cnt - lenp;
          wi            <= b_idx;
          old_cnt       <= b_cnt;
          wstart        <= SPW'(EW'(b_start) + EW'(lenp));
          wstart_en     <= 1'b1;
          state         <= S_SETF;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
